// ===== design/srl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// srl_pkg: shared types and constants for the slew rate limiter
// Sequencer states, limit register width and register indexes.
// ---------------------------------------------------------------------------
package srl_pkg;

  // width of the rising and falling limit registers
  localparam int LIM_WIDTH = 32;

  // register indexes on the configuration port (address bit 2)
  localparam logic REG_RISE = 1'b0;
  localparam logic REG_FALL = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV,
    ST_DECIDE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== design/slew_rate_limiter.sv =====
`default_nettype none
// One request is in flight at a time: in_stall stays high from an accepted request until the
//   result is handed to the output register; the multiply and add steps run only when a limit trips.
// Division: the radix-2 divider takes one quotient bit per cycle.
// Reset: synchronous, active low; clears the sequencer, the held output and both limits.
// ---------------------------------------------------------------------------
// slew_rate_limiter: iterative slew rate limiter
// Takes the rate of change against the held output with a shared restoring
// divider, compares it with the rising and falling limits and, where one
// trips, steps from the held output by time step times that limit.
// ---------------------------------------------------------------------------
module slew_rate_limiter #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int STEP_WIDTH   = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  input  wire        [STEP_WIDTH-1:0]    in_time_step,
  input  wire                            in_restart,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire        [2:0]               paddr,
  input  wire        [31:0]              pwdata,
  output logic       [31:0]              prdata,
  output logic                           pready
);

  import srl_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int TW    = STEP_WIDTH;
  localparam int CNT_W = $clog2(SW + 1);
  localparam int PW    = TW + LIM_WIDTH;
  localparam int CW    = (SW > LIM_WIDTH) ? SW : LIM_WIDTH;
  localparam int AW    = ((SW > PW) ? SW : PW) + 2;
  localparam logic [AW-1:0] SMAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [AW-1:0] SMIN = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  // state and registers
  state_t                 state_r, state_nxt;
  logic [LIM_WIDTH-1:0]   rise_r, fall_r;
  logic [SW-1:0]          held_r, held_nxt;
  logic [SW-1:0]          samp_r, samp_nxt;
  logic [TW-1:0]          dt_r, dt_nxt;
  logic [TW-1:0]          div_r, div_nxt;
  logic [TW-1:0]          rem_r, rem_nxt;
  logic [SW-1:0]          quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   below_r, below_nxt;
  logic                   lneg_r, lneg_nxt;
  logic [LIM_WIDTH-1:0]   lmag_r, lmag_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [SW-1:0]          res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SW-1:0]          out_data_r, out_data_nxt;

  // combinational helpers
  logic                   in_take;
  logic                   out_free;
  logic [SW:0]            diff;
  logic [TW:0]            shifted;
  logic [TW+1:0]          trial;
  logic                   ge;
  logic                   neg;
  logic                   rneg, fneg;
  logic [LIM_WIDTH-1:0]   rmag, fmag;
  logic [CW-1:0]          q_x, rmag_x, fmag_x;
  logic                   rise_hit, fall_hit;
  logic [AW-1:0]          held_x, step_x, sum;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FALL) ? fall_r : rise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= '0;
      fall_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_RISE) begin
        rise_r <= pwdata;
      end else begin
        fall_r <= pwdata;
      end
    end
  end

  // shared divider step: shift in one dividend bit, trial subtract
  assign shifted = {rem_r, quo_r[SW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_r};
  assign ge      = !trial[TW+1];

  // signed difference against the held output
  assign diff = {samp_r[SW-1], samp_r} - {held_r[SW-1], held_r};

  // limit magnitudes and rate compares
  assign rneg     = rise_r[LIM_WIDTH-1];
  assign fneg     = fall_r[LIM_WIDTH-1];
  assign rmag     = rneg ? (~rise_r + 1'b1) : rise_r;
  assign fmag     = fneg ? (~fall_r + 1'b1) : fall_r;
  assign q_x      = CW'(quo_r);
  assign rmag_x   = CW'(rmag);
  assign fmag_x   = CW'(fmag);
  assign neg      = below_r && (quo_r != '0);
  assign rise_hit = (rise_r != '0) &&
                    (neg ? (rneg && (q_x < rmag_x)) : (rneg || (q_x > rmag_x)));
  assign fall_hit = (fall_r != '0) &&
                    (neg ? (!fneg || (q_x > fmag_x)) : (!fneg && (q_x < fmag_x)));

  // exact step from the held output
  assign held_x = {{(AW-SW){held_r[SW-1]}}, held_r};
  assign step_x = lneg_r ? (~AW'(prod_r) + 1'b1) : AW'(prod_r);
  assign sum    = held_x + step_x;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: state_nxt = (rise_hit || fall_hit) ? ST_MUL : ST_DONE;
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    held_nxt      = held_r;
    samp_nxt      = samp_r;
    dt_nxt        = dt_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    below_nxt     = below_r;
    lneg_nxt      = lneg_r;
    lmag_nxt      = lmag_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        // latch the request; a restart reloads the held output
        if (in_take) begin
          samp_nxt = in_sample_in;
          dt_nxt   = in_time_step;
          div_nxt  = (in_time_step == '0) ? TW'(1) : in_time_step;
          if (in_restart) begin
            held_nxt = in_sample_in;
          end
        end
      end
      ST_DIFF: begin
        // magnitude of the difference becomes the dividend
        below_nxt = diff[SW];
        quo_nxt   = diff[SW] ? SW'(~diff + 1'b1) : diff[SW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(SW);
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_nxt = ge ? trial[TW-1:0] : shifted[TW-1:0];
        quo_nxt = {quo_r[SW-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_DECIDE: begin
        // pick the tripped limit, or pass the sample through
        lneg_nxt = rise_hit ? rneg : fneg;
        lmag_nxt = rise_hit ? rmag : fmag;
        res_nxt  = samp_r;
      end
      ST_MUL: begin
        prod_nxt = PW'(dt_r) * PW'(lmag_r);
      end
      ST_ADD: begin
        // saturate to the sample range
        if ($signed(sum) > $signed(SMAX)) begin
          res_nxt = SMAX[SW-1:0];
        end else if ($signed(sum) < $signed(SMIN)) begin
          res_nxt = SMIN[SW-1:0];
        end else begin
          res_nxt = sum[SW-1:0];
        end
      end
      ST_DONE: begin
        // hand the result to the output register and hold it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          held_nxt      = res_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    dt_r       <= dt_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    below_r    <= below_nxt;
    lneg_r     <= lneg_nxt;
    lmag_r     <= lmag_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_DIFF)
    else $error("accepted request did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_r != '0)
    else $error("divisor is zero during division");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < div_r)
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire
